// ----- sv/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
// Each macro checks a property on the rising clock edge, quiet while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ----- sv/mssrd_pkg.sv -----
`timescale 1ns / 1ps

package mssrd_pkg;

	// default timing and duty figures
	localparam int FULL_TIME_MS_DEF = 200;
	localparam int RAMP_TIME_MS_DEF = 256;
	localparam int FULL_DUTY_DEF    = 255;
	localparam int TIMEOUT_MS_DEF   = 2000;

	// motion state codes
	localparam logic [2:0] MS_OPEN_PARCEL = 3'd0;
	localparam logic [2:0] MS_OPEN_MAIL   = 3'd1;
	localparam logic [2:0] MS_LOCKING     = 3'd2;
	localparam logic [2:0] MS_LOCKED      = 3'd3;
	localparam logic [2:0] MS_PARCEL_OPEN = 3'd4;
	localparam logic [2:0] MS_MAIL_OPEN   = 3'd5;
	localparam logic [2:0] MS_ERROR       = 3'd6;
	localparam logic [2:0] MS_OTHER       = 3'd7;

	// previous-state marker before any word has been seen
	localparam logic [3:0] PREV_NONE = 4'd8;

	// calibration steps that test a duty
	localparam logic [3:0] CAL_STEP_OPEN  = 4'd3;
	localparam logic [3:0] CAL_STEP_CLOSE = 4'd6;

	// register indexes
	localparam logic REG_OPEN_DUTY  = 1'b0;
	localparam logic REG_CLOSE_DUTY = 1'b1;

	// brake level on both legs
	localparam logic [7:0] BRAKE_DUTY = 8'hFF;

	typedef enum logic [1:0] {
		DRV_FWD,
		DRV_REV,
		DRV_BRAKE,
		DRV_HOLD
	} drive_kind_t;

	typedef enum logic [1:0] {
		PH_FULL,
		PH_RAMP,
		PH_TARGET
	} ramp_phase_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [2:0]  motion_state;
		logic        calibration_active;
		logic [3:0]  calibration_step;
		logic [7:0]  candidate_duty;
	} item_t;

	typedef struct packed {
		logic [7:0] forward_duty;
		logic [7:0] reverse_duty;
		logic       timeout_fault;
	} result_t;

endpackage

// ----- sv/motor_soft_start_ramp_drive_top.sv -----
// Soft-start ramp drive: three register stages (input, timing/product, ramp/output).
// Words pass the input, timing/product and ramp/output registers; the ramp divide is a reciprocal
// multiply in the ramp/output stage. Throughput: one word per cycle unless result_ready stalls.
// Reset: asynchronous, active low; both target duties go to 128, start time and held
// duties to zero, previous state to "none"; no pipeline word survives reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motor_soft_start_ramp_drive_top
	import mssrd_pkg::*;
#(
	parameter int FULL_TIME_MS = FULL_TIME_MS_DEF,
	parameter int RAMP_TIME_MS = RAMP_TIME_MS_DEF,
	parameter int FULL_DUTY    = FULL_DUTY_DEF,
	parameter int TIMEOUT_MS   = TIMEOUT_MS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [7:0] wr_data
);

	// ramp offset width, product width and reciprocal for the divide by RAMP_TIME_MS
	localparam int RAMP_LOG  = $clog2(RAMP_TIME_MS);
	localparam int T_W       = (RAMP_LOG > 0) ? RAMP_LOG : 1;
	localparam int PROD_W    = 8 + T_W;
	localparam int MUL_W     = PROD_W + 2;
	localparam int RECIP_W   = PROD_W + MUL_W;
	localparam int RAMP_SHIFT = PROD_W + RAMP_LOG;
	localparam longint unsigned RAMP_MUL =
		((64'd1 << RAMP_SHIFT) + RAMP_TIME_MS - 1) / RAMP_TIME_MS;
	localparam logic [MUL_W-1:0] RAMP_MUL_B   = MUL_W'(RAMP_MUL);
	localparam logic [7:0]       FULL_DUTY_B  = 8'(FULL_DUTY);
	localparam logic [31:0]      FULL_TIME_B  = 32'(FULL_TIME_MS);
	localparam logic [31:0]      RAMP_END_B   = 32'(FULL_TIME_MS + RAMP_TIME_MS);
	localparam logic [31:0]      TIMEOUT_B    = 32'(TIMEOUT_MS);

	// configuration registers
	logic [7:0] open_duty_q;
	logic [7:0] close_duty_q;
	logic [7:0] wr_sat;

	// motion tracking state
	logic [31:0] start_time_q;
	logic [3:0]  prev_state_q;
	logic [7:0]  held_fwd_q;
	logic [7:0]  held_rev_q;

	// pipeline registers
	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	drive_kind_t kind_s2;
	ramp_phase_t phase_s2;
	logic        fault_s2;
	logic        neg_s2;
	logic [7:0]  target_s2;
	logic [PROD_W-1:0] prod_s2;
	logic        valid_q;
	result_t     result_q;

	// handshake between stages
	logic adv_s2;
	logic adv_s1;

	// stage one logic
	logic        moving;
	logic        entering;
	logic [31:0] start_eff;
	logic [31:0] elapsed;
	logic        timeout;
	logic [7:0]  t_open;
	logic [7:0]  t_close;
	logic [7:0]  target;
	drive_kind_t kind;
	ramp_phase_t phase;
	logic        neg;
	logic [7:0]  mag;
	logic [31:0] t_off_full;
	logic [T_W-1:0] t_off;
	logic [PROD_W-1:0] prod;

	// stage two logic
	logic [RECIP_W-1:0] recip;
	logic [7:0]  quot;
	logic [8:0]  ramp_sum;
	logic [7:0]  duty;
	logic [7:0]  fwd_next;
	logic [7:0]  rev_next;

	// advance each stage when the one after it has room
	assign adv_s2     = valid_s2 && (!valid_q || result_ready);
	assign adv_s1     = valid_s1 && (!valid_s2 || adv_s2);
	assign item_ready = !valid_s1 || adv_s1;

	// saturate register writes at full duty
	assign wr_sat = (wr_data > FULL_DUTY_B) ? FULL_DUTY_B : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_duty_q  <= 8'd128;
			close_duty_q <= 8'd128;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OPEN_DUTY:  open_duty_q  <= wr_sat;
				REG_CLOSE_DUTY: close_duty_q <= wr_sat;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// latch start time on entry into a moving state, measure elapsed time
	always_comb begin
		moving    = item_s1.motion_state <= MS_LOCKING;
		entering  = moving && (prev_state_q != {1'b0, item_s1.motion_state});
		start_eff = entering ? item_s1.now_ms : start_time_q;
		elapsed   = item_s1.now_ms - start_eff;
		timeout   = moving && (elapsed > TIMEOUT_B);
	end

	// pick targets, with the calibration candidate in place where tested
	always_comb begin
		t_open  = open_duty_q;
		t_close = close_duty_q;
		if (item_s1.calibration_active) begin
			if (item_s1.calibration_step == CAL_STEP_OPEN) begin
				t_open = item_s1.candidate_duty;
			end else if (item_s1.calibration_step == CAL_STEP_CLOSE) begin
				t_close = item_s1.candidate_duty;
			end
		end
	end

	// decode drive kind from state
	always_comb begin
		unique case (item_s1.motion_state) inside
			MS_OPEN_PARCEL, MS_OPEN_MAIL: kind = DRV_FWD;
			MS_LOCKING: kind = DRV_REV;
			MS_LOCKED, MS_PARCEL_OPEN, MS_MAIL_OPEN, MS_ERROR: kind = DRV_BRAKE;
			MS_OTHER: kind = DRV_HOLD;
			default: kind = DRV_HOLD;
		endcase
		if (timeout) begin
			kind = DRV_BRAKE;
		end
	end

	// ramp phase and the product for the linear section
	always_comb begin
		target = (kind == DRV_REV) ? t_close : t_open;
		if (elapsed < FULL_TIME_B) begin
			phase = PH_FULL;
		end else if (elapsed < RAMP_END_B) begin
			phase = PH_RAMP;
		end else begin
			phase = PH_TARGET;
		end
		neg        = target > FULL_DUTY_B;
		mag        = neg ? (target - FULL_DUTY_B) : (FULL_DUTY_B - target);
		t_off_full = elapsed - FULL_TIME_B;
		t_off      = t_off_full[T_W-1:0];
		prod       = PROD_W'(mag) * PROD_W'(t_off);
	end

	// update motion state as each word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			prev_state_q <= PREV_NONE;
			valid_s2     <= 1'b0;
		end else begin
			if (adv_s1) begin
				start_time_q <= start_eff;
				prev_state_q <= {1'b0, item_s1.motion_state};
			end
			if (!valid_s2 || adv_s2) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2   <= kind;
			phase_s2  <= phase;
			fault_s2  <= timeout;
			neg_s2    <= neg;
			target_s2 <= target;
			prod_s2   <= prod;
		end
	end

	// divide by the ramp time through the reciprocal, then form the duty
	always_comb begin
		recip    = RECIP_W'(prod_s2) * RECIP_W'(RAMP_MUL_B);
		quot     = recip[RAMP_SHIFT +: 8];
		ramp_sum = neg_s2 ? ({1'b0, FULL_DUTY_B} + {1'b0, quot})
				: ({1'b0, FULL_DUTY_B} - {1'b0, quot});
		case (phase_s2)
			PH_FULL:   duty = FULL_DUTY_B;
			PH_RAMP:   duty = ramp_sum[7:0];
			PH_TARGET: duty = target_s2;
			default:   duty = target_s2;
		endcase
	end

	// route the duty to a leg, brake, or repeat the held values
	always_comb begin
		case (kind_s2)
			DRV_FWD: begin
				fwd_next = duty;
				rev_next = 8'd0;
			end
			DRV_REV: begin
				fwd_next = 8'd0;
				rev_next = duty;
			end
			DRV_BRAKE: begin
				fwd_next = BRAKE_DUTY;
				rev_next = BRAKE_DUTY;
			end
			default: begin
				fwd_next = held_fwd_q;
				rev_next = held_rev_q;
			end
		endcase
	end

	// result register and held duties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_fwd_q <= '0;
			held_rev_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (adv_s2) begin
				held_fwd_q <= fwd_next;
				held_rev_q <= rev_next;
			end
			if (!valid_q || result_ready) begin
				valid_q <= adv_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_q.forward_duty  <= fwd_next;
			result_q.reverse_duty  <= rev_next;
			result_q.timeout_fault <= fault_s2;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	// a fault always brakes both legs
	`ASSERT_CLK(a_fault_brakes, clk, arst_n, (valid_q && result_q.timeout_fault) |->
		(result_q.forward_duty == BRAKE_DUTY && result_q.reverse_duty == BRAKE_DUTY))
	// a timed-out word is routed to the brake
	`ASSERT_CLK(a_fault_kind, clk, arst_n, (valid_s2 && fault_s2) |-> (kind_s2 == DRV_BRAKE))
	// a stalled middle word is never dropped
	`ASSERT_CLK(a_s2_kept, clk, arst_n, (valid_s2 && !adv_s2) |=> valid_s2)
	// stored targets stay within full duty
	`ASSERT_NEVER(a_duty_sat, clk, arst_n,
		(open_duty_q > FULL_DUTY_B) || (close_duty_q > FULL_DUTY_B))
	// a word only moves into a free or draining stage
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, adv_s1 && valid_s2 && !adv_s2)

endmodule
